FILE: rtl/khte_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the keyed hash table engine.
// No dependencies; every other file imports this package.
package khte_pkg;

    localparam int KIND_W          = 2;
    localparam int KEY_W           = 32;
    localparam int VALUE_W         = 32;
    localparam int STATUS_W        = 3;
    localparam int ENTRY_COUNT_W   = 7;
    localparam int DEF_NUM_BUCKETS = 16;
    localparam int DEF_BUCKET_WAYS = 4;

    localparam logic signed [VALUE_W-1:0] MISS_VALUE = -32'sd987654321;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_LOOKUP = 2'd1,
        KIND_REMOVE = 2'd2
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_NEW     = 3'd0,
        ST_UPDATED = 3'd1,
        ST_FULL    = 3'd2,
        ST_HIT     = 3'd3,
        ST_MISS    = 3'd4
    } status_t;

    // Outcome of one bucket update
    typedef struct packed {
        status_t                    status;
        logic signed [VALUE_W-1:0]  value;
        logic                       wr;
        logic                       inc;
        logic                       dec;
    } upd_ctl_t;

endpackage

FILE: rtl/khte_if.sv
`timescale 1ns / 1ps
// Request and response channel interfaces of the keyed hash table engine.
// Depends on khte_pkg.
interface khte_req_if import khte_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [KIND_W-1:0]          kind;
    logic signed [KEY_W-1:0]    key;
    logic signed [VALUE_W-1:0]  value;

    modport source (output valid, output kind, output key, output value, input ready);
    modport sink   (input valid, input kind, input key, input value, output ready);
endinterface

interface khte_rsp_if import khte_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [STATUS_W-1:0]        status;
    logic signed [VALUE_W-1:0]  result_value;
    logic [ENTRY_COUNT_W-1:0]   entry_count;

    modport source (output valid, output status, output result_value, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input result_value, input entry_count,
                    output ready);
endinterface

FILE: rtl/khte_bucket_hash.sv
`timescale 1ns / 1ps
// Bucket index: key pattern modulo the bucket count. Depends on khte_pkg.
// Power-of-two counts take the low bits at once; others go through registered steps.
module khte_bucket_hash import khte_pkg::*; #(
    parameter int NUM_BUCKETS = DEF_NUM_BUCKETS,
    localparam int BKT_W      = $clog2(NUM_BUCKETS)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [KEY_W-1:0]  key,
    output logic              done,
    output logic [BKT_W-1:0]  bucket
);

    localparam bit FAST = (NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0;

    generate
        if (FAST) begin : g_fast
            assign bucket = key[BKT_W-1:0];
            assign done   = start;
        end else begin : g_serial
            localparam int HALF_W = KEY_W / 2;
            localparam int FOLD_W = HALF_W + BKT_W;
            localparam int RCP_W  = FOLD_W + 1;
            localparam int PROD_W = FOLD_W + RCP_W;
            localparam int SHIFT  = FOLD_W + BKT_W;
            localparam longint unsigned RCP_FULL =
                ((64'd1 << SHIFT) + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS);
            localparam logic [RCP_W-1:0]  RCP    = RCP_W'(RCP_FULL);
            localparam logic [FOLD_W-1:0] FOLD_C = FOLD_W'((1 << HALF_W) % NUM_BUCKETS);
            localparam logic [FOLD_W-1:0] NB     = FOLD_W'(NUM_BUCKETS);

            logic              quot_go_reg;
            logic              rem_go_reg;
            logic              done_reg;
            logic [FOLD_W-1:0] fold_reg;
            logic [FOLD_W-1:0] fold_next;
            logic [HALF_W-1:0] quot_reg;
            logic [HALF_W-1:0] quot_next;
            logic [PROD_W-1:0] prod;
            logic [FOLD_W-1:0] rem_full;
            logic [BKT_W-1:0]  rem_reg;
            logic [BKT_W-1:0]  rem_next;

            // Fold the high half down: 2^16 is FOLD_C modulo the bucket count
            assign fold_next = FOLD_W'(key[KEY_W-1:HALF_W]) * FOLD_C
                             + FOLD_W'(key[HALF_W-1:0]);
            // Quotient by reciprocal multiplication, exact over the whole folded range
            assign prod      = PROD_W'(fold_reg) * PROD_W'(RCP);
            assign quot_next = prod[SHIFT +: HALF_W];
            assign rem_full  = fold_reg - FOLD_W'(quot_reg) * NB;
            assign rem_next  = rem_full[BKT_W-1:0];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    quot_go_reg <= 1'b0;
                    rem_go_reg  <= 1'b0;
                    done_reg    <= 1'b0;
                end
                else
                begin
                    quot_go_reg <= start;
                    rem_go_reg  <= quot_go_reg;
                    done_reg    <= rem_go_reg;
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    fold_reg <= fold_next;
                end
                if (quot_go_reg)
                begin
                    quot_reg <= quot_next;
                end
                if (rem_go_reg)
                begin
                    rem_reg <= rem_next;
                end
            end

            assign bucket = rem_reg;
            assign done   = done_reg;
        end
    endgenerate

endmodule

FILE: rtl/khte_row_mem.sv
`timescale 1ns / 1ps
// Bucket row store: one write port, one read port with registered data.
// Depends on khte_pkg for the default depth and width.
module khte_row_mem import khte_pkg::*; #(
    parameter int DEPTH = DEF_NUM_BUCKETS,
    parameter int WIDTH = DEF_BUCKET_WAYS,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/khte_bucket_update.sv
`timescale 1ns / 1ps
// Compare all ways of one bucket row and build the written-back row.
// Depends on khte_pkg.
module khte_bucket_update import khte_pkg::*; #(
    parameter int BUCKET_WAYS = DEF_BUCKET_WAYS
) (
    input  logic [KIND_W-1:0]              kind,
    input  logic [KEY_W-1:0]               key,
    input  logic [VALUE_W-1:0]             value,
    input  logic [BUCKET_WAYS-1:0]         row_valid,
    input  logic [BUCKET_WAYS*KEY_W-1:0]   row_keys,
    input  logic [BUCKET_WAYS*VALUE_W-1:0] row_values,
    output logic [BUCKET_WAYS-1:0]         new_valid,
    output logic [BUCKET_WAYS*KEY_W-1:0]   new_keys,
    output logic [BUCKET_WAYS*VALUE_W-1:0] new_values,
    output upd_ctl_t                       ctl
);

    localparam int W = BUCKET_WAYS;

    logic [W-1:0]       match;
    logic [W-1:0]       free;
    logic [W-1:0]       match_oh;
    logic [W-1:0]       free_oh;
    logic [VALUE_W-1:0] hit_value;
    logic               hit;
    logic               has_free;

    always_comb
    begin
        hit_value = '0;
        for (int w = 0; w < W; w++)
        begin
            match[w] = row_valid[w] && (row_keys[w*KEY_W +: KEY_W] == key);
            free[w]  = !row_valid[w];
        end
        // Lowest set bit wins
        match_oh = match & (~match + W'(1));
        free_oh  = free & (~free + W'(1));
        hit      = |match;
        has_free = |free;
        for (int w = 0; w < W; w++)
        begin
            if (match_oh[w])
            begin
                hit_value = hit_value | row_values[w*VALUE_W +: VALUE_W];
            end
        end
    end

    always_comb
    begin
        new_valid  = row_valid;
        new_keys   = row_keys;
        new_values = row_values;
        ctl.status = ST_MISS;
        ctl.value  = MISS_VALUE;
        ctl.wr     = 1'b0;
        ctl.inc    = 1'b0;
        ctl.dec    = 1'b0;
        case (kind)
            KIND_INSERT:
            begin
                ctl.value = '0;
                if (hit)
                begin
                    ctl.status = ST_UPDATED;
                    ctl.wr     = 1'b1;
                    for (int w = 0; w < W; w++)
                    begin
                        if (match_oh[w])
                        begin
                            new_values[w*VALUE_W +: VALUE_W] = value;
                        end
                    end
                end
                else if (has_free)
                begin
                    ctl.status = ST_NEW;
                    ctl.wr     = 1'b1;
                    ctl.inc    = 1'b1;
                    for (int w = 0; w < W; w++)
                    begin
                        if (free_oh[w])
                        begin
                            new_valid[w]                     = 1'b1;
                            new_keys[w*KEY_W +: KEY_W]       = key;
                            new_values[w*VALUE_W +: VALUE_W] = value;
                        end
                    end
                end
                else
                begin
                    ctl.status = ST_FULL;
                end
            end
            KIND_LOOKUP:
            begin
                if (hit)
                begin
                    ctl.status = ST_HIT;
                    ctl.value  = hit_value;
                end
            end
            KIND_REMOVE:
            begin
                if (hit)
                begin
                    ctl.status = ST_HIT;
                    ctl.value  = hit_value;
                    ctl.wr     = 1'b1;
                    ctl.dec    = 1'b1;
                    new_valid  = row_valid & ~match_oh;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

FILE: rtl/keyed_hash_table_engine.sv
`timescale 1ns / 1ps
// Keyed hash table engine: a key-to-value map of NUM_BUCKETS buckets x BUCKET_WAYS slots.
// Depends on khte_pkg, khte_if, khte_bucket_hash, khte_row_mem, khte_bucket_update.
//
// Usage:
//   req carries one transaction per request: kind (insert, lookup, remove), key, value.
//   rsp returns one transaction per request: status, result_value and the entry count
//   after the request, in request order.
//   Each bucket is one row of a synchronous memory holding valid bits, keys and values
//   of all its ways. A request reads its row, compares all ways at once and writes the
//   row back before the next request reads, so no forwarding is needed.
//   Request flow: with a power-of-two bucket count the bucket is the low key
//   bits and a request is accepted with its row read, then compared and written back.
//   Otherwise the bucket comes from a remainder unit that folds the key and divides by
//   reciprocal multiplication in registered fold, quotient and remainder steps. A new
//   request is accepted only after the write back of the last one.
//   Reset: after rst_n releases, a clearing pass writes every row empty with
//   req.ready low; the entry count starts at zero.
//   Stall: the result sits in an output register. A new request is accepted while it
//   waits, but its write back holds until rsp takes the pending transaction.
module keyed_hash_table_engine import khte_pkg::*; #(
    parameter int NUM_BUCKETS = DEF_NUM_BUCKETS,
    parameter int BUCKET_WAYS = DEF_BUCKET_WAYS
) (
    input  logic              clk,
    input  logic              rst_n,
    khte_req_if.sink          req,
    khte_rsp_if.source        rsp
);

    localparam int BKT_W  = $clog2(NUM_BUCKETS);
    localparam int TOTAL  = NUM_BUCKETS * BUCKET_WAYS;
    localparam int CNT_RAW = $clog2(TOTAL + 1);
    localparam int CNT_W  = (CNT_RAW > ENTRY_COUNT_W) ? CNT_RAW : ENTRY_COUNT_W;
    localparam int KEYS_W = BUCKET_WAYS * KEY_W;
    localparam int VALS_W = BUCKET_WAYS * VALUE_W;
    localparam int ROW_W  = BUCKET_WAYS + KEYS_W + VALS_W;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_HASH  = 4'b0100,
        S_EXEC  = 4'b1000
    } fsm_state_t;

    fsm_state_t                 state_reg;
    fsm_state_t                 state_next;
    logic [BKT_W-1:0]           clr_idx_reg;
    logic [BKT_W-1:0]           bkt_reg;
    logic [CNT_W-1:0]           count_reg;
    logic [KIND_W-1:0]          kind_reg;
    logic [KEY_W-1:0]           key_reg;
    logic [VALUE_W-1:0]         value_reg;
    logic                       out_valid_reg;
    logic [STATUS_W-1:0]        status_reg;
    logic [VALUE_W-1:0]         result_reg;

    logic                       req_fire;
    logic                       exec_fire;
    logic                       hash_start;
    logic                       hash_done;
    logic [BKT_W-1:0]           hash_bucket;
    logic                       rd_en;
    logic [ROW_W-1:0]           rd_data;
    logic                       wr_en;
    logic [BKT_W-1:0]           wr_addr;
    logic [ROW_W-1:0]           wr_data;
    logic [BUCKET_WAYS-1:0]     new_valid;
    logic [KEYS_W-1:0]          new_keys;
    logic [VALS_W-1:0]          new_values;
    upd_ctl_t                   ctl;

    assign req.ready  = (state_reg == S_IDLE);
    assign req_fire   = req.valid && req.ready;
    assign exec_fire  = (state_reg == S_EXEC) && (!out_valid_reg || rsp.ready);
    assign hash_start = req_fire;

    // Issue the row read as soon as the bucket is known
    assign rd_en = hash_done && ((state_reg == S_IDLE) || (state_reg == S_HASH));

    khte_bucket_hash #(
        .NUM_BUCKETS (NUM_BUCKETS)
    ) u_hash (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (hash_start),
        .key    (req.key),
        .done   (hash_done),
        .bucket (hash_bucket)
    );

    khte_row_mem #(
        .DEPTH (NUM_BUCKETS),
        .WIDTH (ROW_W)
    ) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (hash_bucket),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    khte_bucket_update #(
        .BUCKET_WAYS (BUCKET_WAYS)
    ) u_upd (
        .kind       (kind_reg),
        .key        (key_reg),
        .value      (value_reg),
        .row_valid  (rd_data[VALS_W + KEYS_W +: BUCKET_WAYS]),
        .row_keys   (rd_data[VALS_W +: KEYS_W]),
        .row_values (rd_data[VALS_W-1:0]),
        .new_valid  (new_valid),
        .new_keys   (new_keys),
        .new_values (new_values),
        .ctl        (ctl)
    );

    // Write port: empty rows during the clearing pass, else the updated row
    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_idx_reg;
            wr_data = '0;
        end
        else
        begin
            wr_en   = exec_fire && ctl.wr;
            wr_addr = bkt_reg;
            wr_data = {new_valid, new_keys, new_values};
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_idx_reg == BKT_W'(NUM_BUCKETS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = hash_done ? S_EXEC : S_HASH;
                end
            end
            S_HASH:
            begin
                if (hash_done)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (exec_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_idx_reg <= clr_idx_reg + BKT_W'(1);
            end
            if (exec_fire)
            begin
                // Count moves by one at most: inc and dec never both set
                if (ctl.inc)
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
                else if (ctl.dec)
                begin
                    count_reg <= count_reg - CNT_W'(1);
                end
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: hold the request, the bucket and the pending result
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            kind_reg  <= req.kind;
            key_reg   <= req.key;
            value_reg <= req.value;
        end
        if (rd_en)
        begin
            bkt_reg <= hash_bucket;
        end
        if (exec_fire)
        begin
            status_reg <= ctl.status;
            result_reg <= ctl.value;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.result_value = result_reg;
    // Count changes only at a write back, which waits for the pending result to leave
    assign rsp.entry_count  = count_reg[ENTRY_COUNT_W-1:0];

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TOTAL))
        else $error("entry count exceeds slot total");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !exec_fire |=> count_reg == $past(count_reg))
        else $error("entry count changed without a write back");

    a_exec_done: assert property (@(posedge clk) disable iff (!rst_n)
        exec_fire |=> (state_reg == S_IDLE) && rsp.valid)
        else $error("write back did not present a result");

    a_no_write_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !rd_en)
        else $error("row read overlaps a row write");
`endif

endmodule
